### rtl/core/itp_pkg.sv
// Shared types, character codes and decode functions for the infix to
// postfix converter. Used by every file in rtl/core; depends on nothing.

package itp_pkg;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;

   // Characters with a meaning of their own
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;

   // Status codes on the response channel
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd2;

   // Operator precedence levels
   localparam logic [1:0] PREC_NONE = 2'd0;
   localparam logic [1:0] PREC_ADD  = 2'd1;
   localparam logic [1:0] PREC_MUL  = 2'd2;
   localparam logic [1:0] PREC_POW  = 2'd3;

   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_OPER,
      CLS_OPERAND
   } char_class_type;

   function automatic char_class_type char_class(input logic [CHAR_W-1:0] ch);
      char_class_type cls;
      case (ch)
         CH_SPACE, CH_TAB, CH_NUL:                     cls = CLS_BLANK;
         CH_LPAREN:                                    cls = CLS_OPEN;
         CH_RPAREN:                                    cls = CLS_CLOSE;
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: cls = CLS_OPER;
         default:                                      cls = CLS_OPERAND;
      endcase
      return cls;
   endfunction

   // '(' and anything else ranks lowest
   function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] ch);
      logic [1:0] p;
      case (ch)
         CH_CARET:          p = PREC_POW;
         CH_STAR, CH_SLASH: p = PREC_MUL;
         CH_PLUS, CH_MINUS: p = PREC_ADD;
         default:           p = PREC_NONE;
      endcase
      return p;
   endfunction

endpackage

### rtl/core/itp_stack_mem.sv
// Operator stack storage: one write port, one registered read port, with
// write-to-read forwarding on a same-address collision. Uses itp_pkg.

module itp_stack_mem #(
   parameter int DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [itp_pkg::CHAR_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [itp_pkg::CHAR_W-1:0]  rd_data
);

   logic [itp_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [itp_pkg::CHAR_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a write to the address being read wins
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/infix_to_postfix_converter_top.sv
// Top level of the infix to postfix converter (shunting-yard sequencer).
// Depends on itp_pkg and itp_stack_mem.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_in_char[7:0], req_in_last
//   rsp_      out        rsp_valid/rsp_ready   rsp_out_char[7:0], rsp_out_last,
//                                              rsp_status[1:0]
//
// One request at a time: it is taken in S_IDLE, then one sequencer step per
// cycle. An operand, '(' or a plain push is done on its first step; each
// popped operator is emitted in a step of its own first, and the final flush
// pops every stacked entry before it emits the terminator. The stack memory's
// single read port sets the pop rate: the top entry is re-read every cycle at the next stack pointer.
// Reset empties the stack at once (no clearing pass). A stalled response
// register holds the sequencer only on steps that emit.

module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [itp_pkg::CHAR_W-1:0]    req_in_char,
   input  logic                          req_in_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [itp_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_out_last,
   output logic [itp_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_ZERO = '0;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK,
      S_FLUSH
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in, cnt_dec;
   logic [itp_pkg::CHAR_W-1:0]    char_ff;
   logic                          last_ff;

   logic                          rsp_valid_ff;
   logic [itp_pkg::CHAR_W-1:0]    rsp_char_ff;
   logic                          rsp_last_ff;
   logic [itp_pkg::STATUS_W-1:0]  rsp_status_ff;

   logic                          can_emit;
   logic                          emit;
   logic [itp_pkg::CHAR_W-1:0]    emit_char;
   logic                          emit_last;
   logic [itp_pkg::STATUS_W-1:0]  emit_status;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr, rd_addr;
   logic [itp_pkg::CHAR_W-1:0]    top_char;

   itp_pkg::char_class_type       cls;
   logic                          stack_empty, stack_full;
   logic                          req_fire;

   // Stack memory: always reads the entry that will be on top next cycle
   assign cnt_dec = cnt_in - CNT_ONE;
   assign rd_addr = cnt_dec[ADDR_W-1:0];
   assign wr_addr = cnt_ff[ADDR_W-1:0];

   itp_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (char_ff),
      .rd_addr (rd_addr),
      .rd_data (top_char)
   );

   assign cls         = itp_pkg::char_class(char_ff);
   assign stack_empty = (cnt_ff == CNT_ZERO);
   assign stack_full  = (cnt_ff == CNT_FULL);
   assign can_emit    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;

   // Sequencer step
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wr_en       = 1'b0;
      emit        = 1'b0;
      emit_char   = itp_pkg::CH_NUL;
      emit_last   = 1'b0;
      emit_status = itp_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            case (cls)
               itp_pkg::CLS_BLANK: begin
                  state_in = last_ff ? S_FLUSH : S_IDLE;
               end
               itp_pkg::CLS_CLOSE: begin
                  if (stack_empty) begin
                     if (can_emit) begin
                        emit        = 1'b1;
                        emit_status = itp_pkg::ST_UNMATCHED;
                        state_in    = last_ff ? S_FLUSH : S_IDLE;
                     end
                  end else if (top_char == itp_pkg::CH_LPAREN) begin
                     // matching '(' is dropped silently
                     cnt_in   = cnt_ff - CNT_ONE;
                     state_in = last_ff ? S_FLUSH : S_IDLE;
                  end else if (can_emit) begin
                     emit      = 1'b1;
                     emit_char = top_char;
                     cnt_in    = cnt_ff - CNT_ONE;
                  end
               end
               itp_pkg::CLS_OPEN, itp_pkg::CLS_OPER: begin
                  if ((cls == itp_pkg::CLS_OPER) && !stack_empty &&
                      (itp_pkg::prec_of(top_char) >= itp_pkg::prec_of(char_ff))) begin
                     // pop an operator that binds at least as tightly
                     if (can_emit) begin
                        emit      = 1'b1;
                        emit_char = top_char;
                        cnt_in    = cnt_ff - CNT_ONE;
                     end
                  end else if (!stack_full) begin
                     wr_en    = 1'b1;
                     cnt_in   = cnt_ff + CNT_ONE;
                     state_in = last_ff ? S_FLUSH : S_IDLE;
                  end else if (can_emit) begin
                     emit        = 1'b1;
                     emit_status = itp_pkg::ST_OVERFLOW;
                     state_in    = last_ff ? S_FLUSH : S_IDLE;
                  end
               end
               default: begin
                  // operand passes straight through
                  if (can_emit) begin
                     emit      = 1'b1;
                     emit_char = char_ff;
                     state_in  = last_ff ? S_FLUSH : S_IDLE;
                  end
               end
            endcase
         end
         S_FLUSH: begin
            if (can_emit) begin
               emit = 1'b1;
               if (stack_empty) begin
                  emit_last = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  emit_char = top_char;
                  cnt_in    = cnt_ff - CNT_ONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, stack pointer, request capture and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         char_ff <= req_in_char;
         last_ff <= req_in_last;
      end
      if (emit) begin
         rsp_char_ff   <= emit_char;
         rsp_last_ff   <= emit_last;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
